// ===== src/nltm_pkg.sv =====
// ----------------------------------------------------------------------------
// nltm_pkg
// Shared widths, register indexes and constants of the name list token match.
// ----------------------------------------------------------------------------
package nltm_pkg;

    localparam int MAX_TOKEN_BYTES = 32;
    localparam int BYTE_W          = 8;
    localparam int POS_W           = 6;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 64;
    localparam int BYTES_PER_WORD  = CFG_DATA_W / BYTE_W;
    localparam int WORD_SHIFT      = $clog2(BYTES_PER_WORD);

    localparam logic [BYTE_W-1:0] LIST_SEP = 8'h2C;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TOKEN_LENGTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOKEN_BYTES_0 = 3'd1;

endpackage

// ===== src/name_list_token_match.sv =====
// ----------------------------------------------------------------------------
// name_list_token_match
// Reports whether any comma-separated item of a byte stream equals a token.
// ----------------------------------------------------------------------------
// The block takes one list byte per transaction on s_axis and returns one
// result per list on m_axis (token_found in bit 0 of tdata) when the list ends,
// either on a byte with tlast or on a transaction with the empty-list flag in
// tuser. It sustains one byte per clock cycle while no result waits on a stalled
// m_axis; a result passes through the input register and then the result register
// around the single compare-and-update stage. The token (length and up to
// MAX_TOKEN_BYTES bytes) must be written through the cfg port while the stream is
// idle; the block itself does not enforce this. A zero length never matches.
module name_list_token_match #(
    parameter int MAX_TOKEN_BYTES = nltm_pkg::MAX_TOKEN_BYTES
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [nltm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [nltm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // list byte stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,  // [7:0] list_byte
    input  logic                           s_axis_tlast,  // is_last
    input  logic                           s_axis_tuser,  // [0] is_empty_list
    // result stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [7:0]                     m_axis_tdata   // [0] token_found
);
    import nltm_pkg::*;

    localparam int IDX_W = (MAX_TOKEN_BYTES > 1) ? $clog2(MAX_TOKEN_BYTES) : 1;

    // token configuration
    logic [POS_W-1:0]                        r_tok_len;
    logic [MAX_TOKEN_BYTES-1:0][BYTE_W-1:0]  r_token;
    logic                                    cfg_we;

    // input register
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_last;
    logic              r_in_empty;

    // list state
    logic [POS_W-1:0]  r_pos;
    logic              r_match;
    logic              r_hit;
    logic [POS_W-1:0]  n_pos;
    logic              n_match;
    logic              n_hit;
    logic              n_found;

    // result register
    logic              r_out_valid;
    logic              r_out_found;

    logic              len_usable;
    logic              in_result;
    logic              out_free;
    logic              in_go;
    logic              s_take;
    logic [BYTE_W-1:0] tok_byte;
    logic [POS_W-1:0]  mid_pos;
    logic              mid_match;
    logic              mid_hit;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok_len <= '0;
            r_token   <= '0;
        end else if (cfg_we) begin
            if (i_cfg_index == REG_TOKEN_LENGTH) begin
                r_tok_len <= i_cfg_data[POS_W-1:0];
            end
            for (int k = 0; k < MAX_TOKEN_BYTES; k++) begin
                if (i_cfg_index == CFG_IDX_W'(int'(REG_TOKEN_BYTES_0) + (k >> WORD_SHIFT)))
                begin
                    r_token[k] <= i_cfg_data[(k % BYTES_PER_WORD)*BYTE_W +: BYTE_W];
                end
            end
        end
    end

    // handshake: the input register drains unless its result has nowhere to go
    assign in_result     = r_in_empty || r_in_last;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign in_go         = r_in_valid && (!in_result || out_free);
    assign s_axis_tready = !r_in_valid || in_go;
    assign s_take        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_take) begin
            r_in_valid <= 1'b1;
        end else if (in_go) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_take) begin
            r_in_byte  <= s_axis_tdata;
            r_in_last  <= s_axis_tlast;
            r_in_empty <= s_axis_tuser;
        end
    end

    assign len_usable = (r_tok_len != '0) &&
                        ({1'b0, r_tok_len} <= (POS_W+1)'(MAX_TOKEN_BYTES));
    assign tok_byte   = r_token[r_pos[IDX_W-1:0]];

    always_comb begin
        mid_pos   = r_pos;
        mid_match = r_match;
        mid_hit   = r_hit;
        // a separator closes the current item
        if (r_in_byte == LIST_SEP) begin
            if (len_usable && r_match && r_pos == r_tok_len) begin
                mid_hit = 1'b1;
            end
            mid_pos   = '0;
            mid_match = 1'b1;
        end else if (r_match) begin
            if (len_usable && r_pos < r_tok_len && r_in_byte == tok_byte) begin
                mid_pos = POS_W'(r_pos + 1'b1);
            end else begin
                mid_match = 1'b0;
            end
        end

        n_pos   = mid_pos;
        n_match = mid_match;
        n_hit   = mid_hit;
        n_found = 1'b0;
        if (r_in_empty) begin
            n_pos   = '0;
            n_match = 1'b1;
            n_hit   = 1'b0;
        end else if (r_in_last) begin
            // close the final item, report, then clear
            n_found = mid_hit || (len_usable && mid_match && mid_pos == r_tok_len);
            n_pos   = '0;
            n_match = 1'b1;
            n_hit   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_match <= 1'b1;
            r_hit   <= 1'b0;
        end else if (in_go) begin
            r_pos   <= n_pos;
            r_match <= n_match;
            r_hit   <= n_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_go && in_result) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_go && in_result) begin
            r_out_found <= n_found;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out_found};

endmodule

// ===== src/nltm_checker.sv =====
// ----------------------------------------------------------------------------
// nltm_checker
// Port-level checks of the name list token match, bound to the top level.
// ----------------------------------------------------------------------------
module nltm_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);

    // a result held back keeps its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // the input side only stalls behind a result that is waiting
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without a waiting result");

    // padding bits of the result stay zero
    a_out_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[7:1] == 7'd0)
        else $error("result padding not zero");

    // reset empties the result register
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind name_list_token_match nltm_checker u_nltm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for name_list_token_match: random tokens and name lists
// are streamed in, and every found flag is checked against a local predictor.
// ----------------------------------------------------------------------------
module tb_top;
    import nltm_pkg::*;

    localparam int STALL_LIMIT   = 3000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_AT_BYTE  = 900;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASE_BYTES   = 190;
    localparam int TOKEN_LEN_PLAN [10] = '{1, 32, 0, 63, 33, 4, 17, 2, 31, 9};
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;

    typedef enum int {
        ITEM_EXACT, ITEM_PREFIX, ITEM_LONG, ITEM_FLIPPED, ITEM_NOISE, ITEM_EMPTY
    } t_item_kind;

    // Predicts the found flag of each list and checks the results in order.
    class t_found_flag_board;
        bit [POS_W-1:0]      key_len;
        bit [CFG_DATA_W-1:0] token_word [4];
        bit [POS_W-1:0]      item_pos;
        bit                  item_alive = 1'b1;
        bit                  list_hit;
        bit                  found_due [$];
        int                  fails;
        int                  bytes_taken;

        function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_TOKEN_LENGTH) begin
                key_len = data[POS_W-1:0];
            end else if (idx >= REG_TOKEN_BYTES_0 && idx < REG_TOKEN_BYTES_0 + 3'd4) begin
                token_word[idx - REG_TOKEN_BYTES_0] = data;
            end
        endfunction

        function bit len_ok();
            return key_len != 0 && key_len <= MAX_TOKEN_BYTES;
        endfunction

        function void close_item();
            if (len_ok() && item_alive && item_pos == key_len) begin
                list_hit = 1'b1;
            end
            item_pos   = '0;
            item_alive = 1'b1;
        endfunction

        function void clear_list();
            item_pos   = '0;
            item_alive = 1'b1;
            list_hit   = 1'b0;
        endfunction

        function void note_byte(logic [BYTE_W-1:0] b, logic last, logic empty);
            bytes_taken++;
            if (empty) begin
                // empty-list marker wins over tlast and drops any partial list
                clear_list();
                found_due.push_back(1'b0);
                return;
            end
            if (b == LIST_SEP) begin
                close_item();
            end else if (item_alive) begin
                if (len_ok() && item_pos < key_len &&
                    b == token_word[item_pos[4:3]][item_pos[2:0]*8 +: 8]) begin
                    item_pos++;
                end else begin
                    item_alive = 1'b0;
                end
            end
            if (last) begin
                close_item();
                found_due.push_back(list_hit);
                clear_list();
            end
        endfunction

        function void check_result(logic [7:0] d);
            bit want;
            if (found_due.size() == 0) begin
                $error("token_found: expected none, actual %0d", d[0]);
                fails++;
                return;
            end
            want = found_due.pop_front();
            if (d[0] !== want) begin
                $error("token_found: expected %0d, actual %0d", want, d[0]);
                fails++;
            end
            if (d[7:1] !== 7'd0) begin
                $error("tdata padding: expected 0, actual %0h", d[7:1]);
                fails++;
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [BYTE_W-1:0]     s_axis_tdata;   // [7:0] list_byte
    logic                  s_axis_tlast;   // is_last
    logic                  s_axis_tuser;   // [0] is_empty_list
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [7:0]            m_axis_tdata;   // [0] token_found, [7:1] zero

    t_found_flag_board sb = new();
    logic [BYTE_W-1:0] tok_bytes [MAX_TOKEN_BYTES];
    int                tok_len_cfg;
    logic [BYTE_W-1:0] list_q [$];
    int                burst_left;
    int                idle_cycles;
    int                hold_left;
    bit                hold_done;
    bit [31:0]         rx_cycle;

    name_list_token_match u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_result(m_axis_tdata);
        end
    end

    // Receiver: one long hold-off once HOLD_AT_BYTE bytes are taken, else a rotating pattern
    always @(negedge i_clk) begin
        if (!hold_done && sb.bytes_taken >= HOLD_AT_BYTE) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            case (rx_cycle[7:6])
                2'd0:    m_axis_tready <= 1'b1;
                2'd1:    m_axis_tready <= ($urandom_range(0, 3) != 0);
                2'd2:    m_axis_tready <= ($urandom_range(0, 3) == 0);
                default: m_axis_tready <= rx_cycle[2];
            endcase
        end
        rx_cycle++;
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    function automatic logic [BYTE_W-1:0] plain_byte();
        logic [BYTE_W-1:0] b;
        do b = BYTE_W'($urandom_range(0, 255)); while (b == LIST_SEP);
        return b;
    endfunction

    // Append one list item of the given shape to list_q
    function automatic void add_item(t_item_kind kind);
        int eff;
        int n;
        int p;
        logic [BYTE_W-1:0] b;
        eff = (tok_len_cfg > MAX_TOKEN_BYTES) ? MAX_TOKEN_BYTES : tok_len_cfg;
        case (kind)
            ITEM_EXACT: begin
                for (int k = 0; k < eff; k++) list_q.push_back(tok_bytes[k]);
            end
            ITEM_PREFIX: begin
                n = (eff > 0) ? $urandom_range(0, eff - 1) : 0;
                for (int k = 0; k < n; k++) list_q.push_back(tok_bytes[k]);
            end
            ITEM_LONG: begin
                for (int k = 0; k < eff; k++) list_q.push_back(tok_bytes[k]);
                n = $urandom_range(1, 3);
                for (int k = 0; k < n; k++) list_q.push_back(plain_byte());
            end
            ITEM_FLIPPED: begin
                if (eff == 0) begin
                    list_q.push_back(plain_byte());
                end else begin
                    p = $urandom_range(0, eff - 1);
                    for (int k = 0; k < eff; k++) begin
                        if (k == p) begin
                            do b = plain_byte(); while (b == tok_bytes[k]);
                            list_q.push_back(b);
                        end else begin
                            list_q.push_back(tok_bytes[k]);
                        end
                    end
                end
            end
            ITEM_NOISE: begin
                n = $urandom_range(0, 8);
                for (int k = 0; k < n; k++) list_q.push_back(BYTE_W'($urandom_range(0, 255)));
            end
            default: ;
        endcase
    endfunction

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last, input logic empty);
        @(negedge i_clk);
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 24);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        s_axis_tuser  <= empty;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_byte(b, last, empty);
    endtask

    task automatic send_queue(input bit with_last);
        for (int i = 0; i < list_q.size(); i++) begin
            send_byte(list_q[i], with_last && i == list_q.size() - 1, 1'b0);
        end
    endtask

    // Hold the stream until every pending found flag is back
    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (sb.found_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.note_config(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic load_token(input int len, input bit comma_ok);
        logic [CFG_DATA_W-1:0] w;
        logic [CFG_DATA_W-1:0] filler;
        drain_results();
        for (int k = 0; k < MAX_TOKEN_BYTES; k++) begin
            tok_bytes[k] = comma_ok ? BYTE_W'($urandom_range(0, 255)) : plain_byte();
        end
        for (int i = 0; i < 4; i++) begin
            for (int k = 0; k < 8; k++) w[8*k +: 8] = tok_bytes[8*i + k];
            write_reg(REG_TOKEN_BYTES_0 + CFG_IDX_W'(i), w);
        end
        // upper bits of the length write are junk and must be dropped
        filler = {$urandom, $urandom};
        write_reg(REG_TOKEN_LENGTH, {filler[CFG_DATA_W-1:POS_W], POS_W'(len)});
        if ($urandom_range(0, 1) == 1) begin
            write_reg(REG_SPARE_LO + CFG_IDX_W'($urandom_range(0, 2)), {$urandom, $urandom});
        end
        tok_len_cfg = len;
    endtask

    task automatic send_list(input int n_items, input bit abort);
        int r;
        list_q.delete();
        for (int i = 0; i < n_items; i++) begin
            if (i > 0) list_q.push_back(LIST_SEP);
            r = $urandom_range(0, 8);
            add_item((r > 5) ? ITEM_EXACT : t_item_kind'(r));
        end
        if ($urandom_range(0, 9) == 0) list_q.push_back(LIST_SEP);
        if (abort || list_q.size() == 0) begin
            // partial list, then the empty-list marker closes it
            send_queue(1'b0);
            send_byte(BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
        end else begin
            send_queue(1'b1);
        end
    endtask

    initial begin
        int goal;
        i_rst_n       <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= '0;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        s_axis_tuser  <= 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // zero token length after reset: a single zero byte must not match
        send_byte(8'h00, 1'b1, 1'b0);

        load_token(3, 1'b0);
        list_q.delete();
        add_item(ITEM_EXACT);
        send_queue(1'b1);
        list_q.delete();
        add_item(ITEM_LONG);
        list_q.push_back(LIST_SEP);
        add_item(ITEM_PREFIX);
        list_q.push_back(LIST_SEP);
        add_item(ITEM_FLIPPED);
        send_queue(1'b1);
        // leading empty item, exact item, trailing comma
        list_q.delete();
        list_q.push_back(LIST_SEP);
        add_item(ITEM_EXACT);
        list_q.push_back(LIST_SEP);
        send_queue(1'b1);
        // exact item abandoned by an empty-list marker that also carries tlast
        list_q.delete();
        add_item(ITEM_EXACT);
        send_queue(1'b0);
        send_byte(8'hFF, 1'b1, 1'b1);
        send_byte(LIST_SEP, 1'b1, 1'b0);

        foreach (TOKEN_LEN_PLAN[p]) begin
            load_token(TOKEN_LEN_PLAN[p], $urandom_range(0, 5) == 0);
            goal = sb.bytes_taken + PHASE_BYTES;
            while (sb.bytes_taken < goal) begin
                if (hold_left == 0 && $urandom_range(0, 39) == 0) drain_results();
                if ($urandom_range(0, 11) == 0) begin
                    send_byte(BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                              $urandom_range(0, 3) == 0);
                end else begin
                    send_list($urandom_range(1, 5), $urandom_range(0, 15) == 0);
                end
            end
        end

        drain_results();
        if (sb.fails == 0 && sb.found_due.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
